/* rtl/prep_pkg.sv */
// ----------------------------------------------------------------------------
// prep_pkg
// Shared codes and widths for the passive reply endpoint parser.
// ----------------------------------------------------------------------------
`default_nettype none

package prep_pkg;

	// result error codes
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
	localparam logic [2:0] ERR_NO_CLOSE  = 3'd2;
	localparam logic [2:0] ERR_BAD_FIELD = 3'd3;
	localparam logic [2:0] ERR_OVER_MAX  = 3'd4;
	localparam logic [2:0] ERR_COUNT     = 3'd5;

	// parse phase codes
	localparam logic [1:0] PH_BEFORE = 2'd0;
	localparam logic [1:0] PH_INSIDE = 2'd1;
	localparam logic [1:0] PH_AFTER  = 2'd2;

	// field mode codes
	localparam logic [1:0] FM_EMPTY  = 2'd0;
	localparam logic [1:0] FM_SPACE  = 2'd1;
	localparam logic [1:0] FM_DIGITS = 2'd2;

	// limits
	localparam logic [8:0] MAX_OCTET   = 9'd255;
	localparam logic [8:0] SAT_VALUE   = 9'd256;
	localparam logic [2:0] FIELD_COUNT = 3'd6;

	// characters
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

endpackage

`default_nettype wire

/* rtl/passive_reply_endpoint_parser_unit.sv */
// An accepted byte is held in the input register and parsed from there; when it
// is the last byte of a reply, the output register loads its result as that
// byte leaves the input register.
// Throughput: one byte per cycle; the input register stalls only while a
// finished result waits in the output register and another reply ends.
// Reset: arst_n clears the parse state and both valid flags at once.
// ----------------------------------------------------------------------------
// passive_reply_endpoint_parser_unit
// Parses a passive-mode reply byte stream into address, port and error code.
// ----------------------------------------------------------------------------
`default_nettype none

module passive_reply_endpoint_parser_unit
	import prep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  char_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      address,
	output logic [15:0]      port_number,
	output logic [2:0]       status_code
);

	// input stage
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	// parse state
	logic [1:0]  phase_q;
	logic [8:0]  value_q;
	logic [1:0]  mode_q;
	logic [2:0]  done_q;
	logic [2:0]  fault_q;
	logic [47:0] asm_q;

	// next parse state
	logic [1:0]  phase_d;
	logic [8:0]  value_d;
	logic [1:0]  mode_d;
	logic [2:0]  done_d;
	logic [2:0]  fault_d;
	logic [47:0] asm_d;
	logic [2:0]  code_d;

	logic        advance;
	logic        is_digit;
	logic        is_space;
	logic [12:0] value_mul;
	logic        taking;

	// the stage moves unless a reply ends while the output beat is held
	assign advance    = valid_s1 && !(last_s1 && result_valid && !result_ready);
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			char_s1 <= char_byte;
			last_s1 <= last_byte;
		end
	end

	// character classes and times-ten accumulate
	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_space  = (char_s1 == CH_SPACE) || ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR));
	assign value_mul = {1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0}
		+ {5'd0, char_s1 - CH_ZERO};
	assign taking    = (fault_q == ERR_OK) && (done_q < FIELD_COUNT);

	// parse one byte
	always_comb begin
		phase_d = phase_q;
		value_d = value_q;
		mode_d  = mode_q;
		done_d  = done_q;
		fault_d = fault_q;
		asm_d   = asm_q;
		case (phase_q)
			PH_BEFORE: begin
				if (char_s1 == CH_OPEN) begin
					phase_d = PH_INSIDE;
				end
			end
			PH_INSIDE: begin
				if (char_s1 == CH_CLOSE || (taking && char_s1 == CH_COMMA)) begin
					if (char_s1 == CH_CLOSE) begin
						phase_d = PH_AFTER;
					end
					// close the current field
					if (taking) begin
						if (mode_q == FM_DIGITS) begin
							if (value_q > MAX_OCTET) begin
								fault_d = ERR_OVER_MAX;
							end else begin
								asm_d  = {asm_q[39:0], value_q[7:0]};
								done_d = done_q + 3'd1;
							end
						end else if (mode_q == FM_SPACE || char_s1 == CH_COMMA) begin
							fault_d = ERR_BAD_FIELD;
						end
						value_d = '0;
						mode_d  = FM_EMPTY;
					end
				end else if (taking) begin
					if (is_digit) begin
						value_d = (value_mul > 13'(MAX_OCTET)) ? SAT_VALUE : value_mul[8:0];
						mode_d  = FM_DIGITS;
					end else if (is_space && mode_q != FM_DIGITS) begin
						mode_d = FM_SPACE;
					end else begin
						fault_d = ERR_BAD_FIELD;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// reply verdict in priority order
	always_comb begin
		if (phase_d == PH_BEFORE) begin
			code_d = ERR_NO_OPEN;
		end else if (phase_d == PH_INSIDE) begin
			code_d = ERR_NO_CLOSE;
		end else if (fault_d != ERR_OK) begin
			code_d = fault_d;
		end else if (done_d != FIELD_COUNT) begin
			code_d = ERR_COUNT;
		end else begin
			code_d = ERR_OK;
		end
	end

	// parse state registers, cleared at the end of each reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEFORE;
			value_q <= '0;
			mode_q  <= FM_EMPTY;
			done_q  <= '0;
			fault_q <= ERR_OK;
			asm_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_BEFORE;
				value_q <= '0;
				mode_q  <= FM_EMPTY;
				done_q  <= '0;
				fault_q <= ERR_OK;
				asm_q   <= '0;
			end else begin
				phase_q <= phase_d;
				value_q <= value_d;
				mode_q  <= mode_d;
				done_q  <= done_d;
				fault_q <= fault_d;
				asm_q   <= asm_d;
			end
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_code <= code_d;
			if (code_d == ERR_OK) begin
				address     <= asm_d[47:16];
				port_number <= asm_d[15:0];
			end else begin
				address     <= '0;
				port_number <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/prep_checker.sv */
// ----------------------------------------------------------------------------
// prep_checker
// Port-level checks for the passive reply endpoint parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module prep_checker
	import prep_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        last_byte,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [31:0] address,
	input wire logic [15:0] port_number,
	input wire logic [2:0]  status_code
);

	// a held output beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(address)
			&& $stable(port_number) && $stable(status_code))
		else $error("output beat changed while stalled");

	// failed replies carry no endpoint
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status_code != ERR_OK |-> address == '0 && port_number == '0)
		else $error("endpoint not zero on error");

	// error code range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status_code <= ERR_COUNT)
		else $error("error code out of range");

	// a fresh result follows an accepted last byte
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready && last_byte, 2))
		else $error("result without a last byte");

endmodule

bind passive_reply_endpoint_parser_unit prep_checker u_prep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.last_byte    (last_byte),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.address      (address),
	.port_number  (port_number),
	.status_code  (status_code)
);

`default_nettype wire
